// ===== rtl/gsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsfp_pkg: shared types and constants of the gas sensor frame parser
// Header byte values, field positions within a frame and the struct that
// carries one decoded result from the frame tracker to the top level.
// ----------------------------------------------------------------------------
package gsfp_pkg;

	localparam logic [7:0] START_BYTE    = 8'hFF;
	localparam logic [7:0] HEADER_SECOND = 8'h04;
	localparam logic [7:0] HEADER_THIRD  = 8'h03;

	// frame positions of the concentration bytes
	localparam int unsigned HIGH_POS = 4;
	localparam int unsigned LOW_POS  = 5;

	typedef struct packed {
		logic        emit;
		logic [15:0] ppm_tenths;
		logic        checksum_ok;
	} gsfp_result_t;

endpackage

// ===== rtl/gsfp_frame.sv =====
// ----------------------------------------------------------------------------
// gsfp_frame: frame position tracker and field decoder
// Holds the byte position, running sum and captured level bytes; decodes the
// byte presented on step and reports a result on the last byte of a frame.
// ----------------------------------------------------------------------------
module gsfp_frame
	import gsfp_pkg::*;
#(
	parameter int unsigned FRAME_LENGTH = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	output gsfp_result_t res
);

	localparam int unsigned PosW = $clog2(FRAME_LENGTH);
	localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);
	localparam logic [PosW-1:0] PosOne  = PosW'(1);
	localparam logic [PosW-1:0] PosTwo  = PosW'(2);
	localparam logic [PosW-1:0] PosHigh = PosW'(HIGH_POS);
	localparam logic [PosW-1:0] PosLow  = PosW'(LOW_POS);

	logic [PosW-1:0] pos_q, pos_nxt;
	logic [7:0]      sum_q, sum_nxt;
	logic [7:0]      level_high_q, level_high_nxt;
	logic [7:0]      level_low_q, level_low_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum_q        <= '0;
			level_high_q <= '0;
			level_low_q  <= '0;
		end else if (step) begin
			pos_q        <= pos_nxt;
			sum_q        <= sum_nxt;
			level_high_q <= level_high_nxt;
			level_low_q  <= level_low_nxt;
		end
	end

	always_comb begin
		pos_nxt         = pos_q;
		sum_nxt         = sum_q;
		level_high_nxt  = level_high_q;
		level_low_nxt   = level_low_q;
		res.emit        = 1'b0;
		res.ppm_tenths  = {level_high_q, level_low_q};
		res.checksum_ok = (rx_byte == 8'(8'd0 - sum_q));
		if (pos_q == '0) begin
			// hunt: drop anything but the start byte
			if (rx_byte == START_BYTE) begin
				sum_nxt = '0;
				pos_nxt = PosOne;
			end
		end else if (pos_q == PosOne || pos_q == PosTwo) begin
			if (rx_byte != ((pos_q == PosOne) ? HEADER_SECOND : HEADER_THIRD)) begin
				pos_nxt = '0;
			end else begin
				sum_nxt = sum_q + rx_byte;
				pos_nxt = pos_q + PosOne;
			end
		end else if (pos_q < LastPos) begin
			sum_nxt = sum_q + rx_byte;
			if (pos_q == PosHigh) begin
				level_high_nxt = rx_byte;
			end
			if (pos_q == PosLow) begin
				level_low_nxt = rx_byte;
			end
			pos_nxt = pos_q + PosOne;
		end else begin
			res.emit = step;
			pos_nxt  = '0;
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LastPos)
		else $error("frame position past last byte");

	a_emit_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |=> pos_q == '0)
		else $error("position not rewound after frame end");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pos_q == '0 && rx_byte == START_BYTE) |=> (pos_q == PosOne && sum_q == '0))
		else $error("start byte did not open a frame");

	a_header_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pos_q == PosOne && rx_byte != HEADER_SECOND) |=> pos_q == '0)
		else $error("header mismatch did not return to hunting");
`endif

endmodule

// ===== rtl/gas_sensor_uart_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_uart_frame_parser_core: nine-byte sensor frame parser
// Input byte register, frame tracker and result register with valid/ready
// handshakes on both sides.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present one received serial byte on rx_byte with in_valid;
//   a transfer happens when in_valid and in_ready are both high.
//   Output channel: out_valid marks a decoded frame on ppm_tenths (byte 4
//   high, byte 5 low) and checksum_ok; a transfer happens with out_ready.
//   Only the last byte of a frame (after the 0xFF 0x04 0x03 header) yields a
//   result; every other byte updates internal state and produces nothing.
//   Path: a frame's last byte is decoded from the input register and its
//   result loaded into the result register, which drives the outputs; the
//   output transfer can come no earlier than that load.
//   Throughput: one byte per cycle while the result register is free or
//   draining, set by the single decode step between the two registers.
//   Stall: while a result waits, the next byte still enters the input
//   register; the byte held there is decoded once the result register is free
//   or is being emptied in the same cycle.
//   Reset: arst_n clears the frame position, running sum, level bytes and
//   both valid flags; the parser starts out hunting for the start byte.
// ----------------------------------------------------------------------------
module gas_sensor_uart_frame_parser_core
	import gsfp_pkg::*;
#(
	parameter int unsigned FRAME_LENGTH = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] ppm_tenths,
	output logic        checksum_ok
);

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         advance;
	gsfp_result_t res;

	logic         out_valid_q;
	logic [15:0]  ppm_tenths_q;
	logic         checksum_ok_q;

	// decode the held byte when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register: take a new byte, or drop the held one once decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	gsfp_frame #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(rx_byte_s1),
		.res    (res)
	);

	// result register: load on a frame end, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			ppm_tenths_q  <= res.ppm_tenths;
			checksum_ok_q <= res.checksum_ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign ppm_tenths  = ppm_tenths_q;
	assign checksum_ok = checksum_ok_q;

endmodule
